// File: src/modular_inverse_assert.svh
// Assertion macros shared by the modular inverse RTL.
`ifndef MODULAR_INVERSE_ASSERT_SVH
`define MODULAR_INVERSE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MINV_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("modular_inverse: assertion failed");

// Next-cycle implication, disabled during reset.
`define MINV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("modular_inverse: assertion failed");

`endif

// File: src/minv_pkg.sv
// Types shared by the modular inverse block.
`timescale 1ns / 1ps

package minv_pkg;

   typedef struct packed {
      logic [31:0] value;
      logic [31:0] modulus;
   } minv_req_type;

   typedef struct packed {
      logic [31:0] inverse;
      logic        no_inverse;
   } minv_rsp_type;

   typedef struct packed {
      logic running;
      logic last;
   } minv_div_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REDUCE,
      ST_SEED,
      ST_LOOP,
      ST_DIVIDE,
      ST_UPDATE,
      ST_FINISH
   } minv_state_type;

endpackage

// File: src/minv_divider.sv
// Shared restoring divider, one quotient bit per cycle, with Horner accumulation of q * coef.
`timescale 1ns / 1ps

module minv_divider #(
   parameter int W = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [W-1:0]                  dividend,
   input  logic [W-1:0]                  divisor,
   input  logic [W-1:0]                  coef,
   output logic [W-1:0]                  rem,
   output logic [W-1:0]                  acc,
   output minv_pkg::minv_div_stat_type   stat
);
   import minv_pkg::*;

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  dvd_ff, dvd_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  coef_ff, coef_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [W:0]    rem_sh;
   logic [W+1:0]  diff;
   logic          take;
   logic [W:0]    acc_sum;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[W-1]};
      diff    = {1'b0, rem_sh} - {2'b00, dsr_ff};
      take    = ~diff[W+1];
      acc_sum = {acc_ff, 1'b0} + {1'b0, (take ? coef_ff : {W{1'b0}})};
   end

   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      coef_in = coef_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         acc_in  = '0;
         coef_in = coef;
         cnt_in  = CW'(W);
      end else if (cnt_ff != '0) begin
         dvd_in = {dvd_ff[W-2:0], 1'b0};
         rem_in = take ? diff[W-1:0] : rem_sh[W-1:0];
         acc_in = acc_sum[W-1:0];
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
      coef_ff <= coef_in;
   end

   assign rem          = rem_ff;
   assign acc          = acc_ff;
   assign stat.running = (cnt_ff != '0);
   assign stat.last    = (cnt_ff == CW'(1));

endmodule

// File: src/modular_inverse.sv
// Modular inverse top level: extended Euclid sequencer around one shared divider.
// An accepted word passes check, reduction and seed, then one divide and update per Euclid round.
// Each round runs the divider over all W quotient bits, W = DATA_WIDTH; modulus 0 or 1 goes straight to finish.
// busy is low again in the strobe cycle, so a new word may start then; the receiver cannot stall.
// Reset is synchronous, active high: sequencer to idle, divider count and strobe cleared.
`timescale 1ns / 1ps

module modular_inverse #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  minv_pkg::minv_req_type req_word,
   output logic                   rsp_strobe,
   output minv_pkg::minv_rsp_type rsp_word
);
   import minv_pkg::*;
   `include "modular_inverse_assert.svh"

   localparam int W = DATA_WIDTH;

   minv_state_type    state_ff, state_in;
   minv_div_stat_type div_stat;

   logic [W-1:0] v_ff, v_in;
   logic [W-1:0] m_ff, m_in;
   logic [W-1:0] r_prev_ff, r_prev_in;
   logic [W-1:0] r_cur_ff, r_cur_in;
   logic [W-1:0] c_prev_ff, c_prev_in;
   logic [W-1:0] c_cur_ff, c_cur_in;
   logic         neg_ff, neg_in;
   logic [W-1:0] inv_ff, inv_in;
   logic         none_ff, none_in;
   logic         strobe_ff, strobe_in;

   logic         div_load;
   logic [W-1:0] div_dividend;
   logic [W-1:0] div_divisor;
   logic [W-1:0] div_rem;
   logic [W-1:0] div_acc;

   logic [63:0]  v_wide;
   logic [63:0]  m_wide;
   logic [63:0]  inv_wide;
   logic [W:0]   c_sum;

   assign v_wide   = {32'd0, req_word.value};
   assign m_wide   = {32'd0, req_word.modulus};
   assign inv_wide = {{(64 - W){1'b0}}, inv_ff};
   assign c_sum    = {1'b0, c_prev_ff} + {1'b0, div_acc};

   minv_divider #(
      .W(W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .coef     (c_cur_ff),
      .rem      (div_rem),
      .acc      (div_acc),
      .stat     (div_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_CHECK;
         ST_CHECK:  state_in = (m_ff <= W'(1)) ? ST_FINISH : ST_REDUCE;
         ST_REDUCE: if (div_stat.last) state_in = ST_SEED;
         ST_SEED:   state_in = ST_LOOP;
         ST_LOOP:   state_in = (r_cur_ff == '0) ? ST_FINISH : ST_DIVIDE;
         ST_DIVIDE: if (div_stat.last) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_LOOP;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      busy         = (state_ff != ST_IDLE);
      div_load     = 1'b0;
      div_dividend = r_prev_ff;
      div_divisor  = r_cur_ff;
      strobe_in    = 1'b0;
      unique case (state_ff)
         ST_CHECK: begin
            div_load     = (m_ff > W'(1));
            div_dividend = v_ff;
            div_divisor  = m_ff;
         end
         ST_LOOP: begin
            div_load = (r_cur_ff != '0);
         end
         ST_FINISH: begin
            strobe_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      v_in      = v_ff;
      m_in      = m_ff;
      r_prev_in = r_prev_ff;
      r_cur_in  = r_cur_ff;
      c_prev_in = c_prev_ff;
      c_cur_in  = c_cur_ff;
      neg_in    = neg_ff;
      inv_in    = inv_ff;
      none_in   = none_ff;
      unique case (state_ff)
         ST_IDLE: begin
            v_in = v_wide[W-1:0];
            m_in = m_wide[W-1:0];
         end
         ST_SEED: begin
            r_prev_in = m_ff;
            r_cur_in  = div_rem;
            c_prev_in = '0;
            c_cur_in  = W'(1);
            neg_in    = 1'b0;
         end
         ST_UPDATE: begin
            r_prev_in = r_cur_ff;
            r_cur_in  = div_rem;
            c_prev_in = c_cur_ff;
            c_cur_in  = c_sum[W-1:0];
            neg_in    = ~neg_ff;
         end
         ST_FINISH: begin
            inv_in  = '0;
            none_in = 1'b0;
            priority if (m_ff == '0) begin
               none_in = 1'b1;
            end else if (m_ff == W'(1)) begin
               none_in = 1'b0;
            end else if (r_prev_ff != W'(1)) begin
               none_in = 1'b1;
            end else if (c_prev_ff >= m_ff) begin
               inv_in = '0;
            end else if (!neg_ff) begin
               // coefficient of the gcd is negative
               inv_in = m_ff - c_prev_ff;
            end else begin
               inv_in = c_prev_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      v_ff      <= v_in;
      m_ff      <= m_in;
      r_prev_ff <= r_prev_in;
      r_cur_ff  <= r_cur_in;
      c_prev_ff <= c_prev_in;
      c_cur_ff  <= c_cur_in;
      neg_ff    <= neg_in;
      inv_ff    <= inv_in;
      none_ff   <= none_in;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_word.inverse    = inv_wide[31:0];
   assign rsp_word.no_inverse = none_ff;

   `MINV_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `MINV_ASSERT_NEXT(a_finish_strobe, clock, reset, state_ff == ST_FINISH, rsp_strobe)
   `MINV_ASSERT_IMPL(a_none_zero, clock, reset, rsp_strobe && none_ff, inv_ff == '0)
   `MINV_ASSERT_IMPL(a_inv_range, clock, reset, rsp_strobe && !none_ff && (m_ff > W'(1)), inv_ff < m_ff)
   `MINV_ASSERT_NEXT(a_div_run, clock, reset, div_load, div_stat.running && (state_ff != ST_IDLE))

endmodule

// File: sim/tb_modular_inverse.sv
// Self-checking testbench for the modular_inverse block.
`timescale 1ns / 1ps

module tb_modular_inverse;
   import minv_pkg::*;

   localparam int          WORD_BITS    = 32;
   localparam logic [63:0] WORD_MASK    = (64'd1 << WORD_BITS) - 64'd1;
   localparam int          STALL_LIMIT  = 20000;
   localparam int          DRAIN_CYCLES = 4 + WORD_BITS + 47 * (WORD_BITS + 2);

   typedef struct {
      minv_req_type operands;
      minv_rsp_type answer;
   } inverse_job_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   minv_req_type req_word = '0;
   logic         rsp_strobe;
   minv_rsp_type rsp_word;

   inverse_job_type awaited_inverses[$];
   int           mismatches      = 0;
   int           words_accepted  = 0;
   int           results_checked = 0;
   int           refused_count   = 0;
   int           burst_left      = 0;
   bit           pacing_on       = 1'b1;
   int           quiet_cycles;

   modular_inverse #(.DATA_WIDTH(WORD_BITS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always #6 clock = ~clock;

   // Extended Euclid on coefficient magnitudes; sign flips every round.
   function automatic minv_rsp_type predict_inverse(input minv_req_type word);
      logic [63:0]  v, m, r_prev, r_cur, r_next, c_prev, c_cur, c_next, q, res;
      logic         cur_neg;
      minv_rsp_type rsp;
      rsp = '0;
      v = 64'(word.value) & WORD_MASK;
      m = 64'(word.modulus) & WORD_MASK;
      if (m == 64'd1)
         return rsp;
      if (m == 64'd0) begin
         rsp.no_inverse = 1'b1;
         return rsp;
      end
      r_prev  = m;
      r_cur   = v % m;
      c_prev  = 64'd0;
      c_cur   = 64'd1;
      cur_neg = 1'b0;
      while (r_cur != 64'd0) begin
         q       = r_prev / r_cur;
         r_next  = r_prev - q * r_cur;
         c_next  = c_prev + q * c_cur;
         r_prev  = r_cur;
         r_cur   = r_next;
         c_prev  = c_cur;
         c_cur   = c_next;
         cur_neg = !cur_neg;
      end
      if (r_prev != 64'd1) begin
         rsp.no_inverse = 1'b1;
         return rsp;
      end
      if (!cur_neg)
         res = (c_prev >= m) ? 64'd0 : m - c_prev;
      else
         res = c_prev % m;
      if (res >= m)
         res = 64'd0;
      rsp.inverse = res[31:0];
      return rsp;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
   endtask

   // Sender pacing: bursts of random length, gaps of random length between them.
   task automatic pace();
      int gap;
      if (!pacing_on)
         return;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 1700) : $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clock);
      burst_left = $urandom_range(0, 11);
   endtask

   task automatic send_word(input logic [31:0] value, input logic [31:0] modulus);
      minv_req_type word;
      inverse_job_type job;
      word.value    = value;
      word.modulus  = modulus;
      start        <= 1'b1;
      req_word     <= word;
      do @(posedge clock); while (busy);
      job.operands = word;
      job.answer   = predict_inverse(word);
      awaited_inverses.push_back(job);
      words_accepted++;
      pace();
   endtask

   function automatic minv_req_type random_operands();
      minv_req_type word;
      int           pick, f, k;
      logic [31:0]  fa, fb, ft;
      pick         = $urandom_range(0, 99);
      word.value   = $urandom;
      word.modulus = $urandom;
      if (pick < 30) begin
      end else if (pick < 45) begin
         word.modulus[0] = 1'b1;
      end else if (pick < 55) begin
         word.modulus = $urandom_range(2, 300);
      end else if (pick < 65) begin
         if (word.modulus != 0)
            word.value = word.value % word.modulus;
      end else if (pick < 75) begin
         f            = $urandom_range(2, 251);
         word.value   = f * $urandom_range(1, 32'hFFFF_FFFF / f);
         word.modulus = f * $urandom_range(1, 32'hFFFF_FFFF / f);
      end else if (pick < 83) begin
         // consecutive Fibonacci numbers: the longest remainder chains
         k  = $urandom_range(2, 45);
         fa = 32'd1;
         fb = 32'd1;
         repeat (k) begin
            ft = fa + fb;
            fb = fa;
            fa = ft;
         end
         word.value   = $urandom_range(0, 1) ? fb : fa;
         word.modulus = (word.value == fb) ? fa : fb;
      end else if (pick < 90) begin
         word.modulus = $urandom_range(0, 2);
         if ($urandom_range(0, 2) == 0)
            word.value = '0;
      end else if (pick < 95) begin
         word.value = word.modulus * $urandom_range(0, 3);
      end else begin
         word.value   = 32'hFFFF_FFFF - $urandom_range(0, 64);
         word.modulus = 32'hFFFF_FFFF - $urandom_range(0, 64);
      end
      return word;
   endfunction

   always @(posedge clock) begin
      inverse_job_type job;
      if (!reset && rsp_strobe) begin
         if (awaited_inverses.size() == 0) begin
            report_mismatch($sformatf("unexpected result inverse=%h no_inverse=%b",
                                      rsp_word.inverse, rsp_word.no_inverse));
         end else begin
            job = awaited_inverses.pop_front();
            results_checked++;
            if (job.answer.no_inverse)
               refused_count++;
            if (rsp_word.inverse !== job.answer.inverse)
               report_mismatch($sformatf("value=%h modulus=%h inverse got %h want %h",
                                         job.operands.value, job.operands.modulus,
                                         rsp_word.inverse, job.answer.inverse));
            if (rsp_word.no_inverse !== job.answer.no_inverse)
               report_mismatch($sformatf("value=%h modulus=%h no_inverse got %b want %b",
                                         job.operands.value, job.operands.modulus,
                                         rsp_word.no_inverse, job.answer.no_inverse));
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // Moduli of zero, one and two, and a zero value.
   task automatic test_special_moduli();
      send_word(32'h0000_0000, 32'h0000_0000);
      send_word(32'h0000_0005, 32'h0000_0000);
      send_word(32'hFFFF_FFFF, 32'h0000_0000);
      send_word(32'h0000_0000, 32'h0000_0001);
      send_word(32'hFFFF_FFFF, 32'h0000_0001);
      send_word(32'h0000_0001, 32'h0000_0002);
      send_word(32'h0000_0000, 32'h0000_0002);
      send_word(32'hFFFF_FFFF, 32'h0000_0002);
   endtask

   // Field extremes, reduction, multiples, common factors, longest chains.
   task automatic test_operand_extremes();
      send_word(32'h0000_0001, 32'hFFFF_FFFF);
      send_word(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_word(32'h0000_0002, 32'hFFFF_FFFB);
      send_word(32'hDEAD_BEEF, 32'hFFFF_FFFB);
      send_word(32'h0000_0011, 32'h0000_0005);
      send_word(32'h0000_000F, 32'h0000_0005);
      send_word(32'h0000_0006, 32'h0000_0009);
      send_word(32'h0000_0003, 32'h0000_0007);
      send_word(32'hAAAA_AAAA, 32'h5555_5555);
      send_word(32'h5555_5555, 32'hAAAA_AAAA);
      send_word(32'h8000_0000, 32'h7FFF_FFFF);
      send_word(32'd1836311903, 32'd2971215073);
      send_word(32'd2971215073, 32'd1836311903);
   endtask

   // Start held high: each word follows the previous one with no gap.
   task automatic test_back_to_back(input int count);
      minv_req_type word;
      pacing_on = 1'b0;
      repeat (count) begin
         word = random_operands();
         send_word(word.value, word.modulus);
      end
      pacing_on = 1'b1;
   endtask

   task automatic test_random_mix(input int count);
      minv_req_type word;
      repeat (count) begin
         word = random_operands();
         send_word(word.value, word.modulus);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_special_moduli();
      test_operand_extremes();
      test_back_to_back(40);
      test_random_mix(307);
      start <= 1'b0;
      while (awaited_inverses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run: %0d words sent, %0d results checked", words_accepted, results_checked);
      $display("run: %0d without inverse, %0d mismatches", refused_count, mismatches);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/minv_pkg.sv
src/minv_divider.sv
src/modular_inverse.sv
sim/tb_modular_inverse.sv
